// ----- hw/rtl/sbsa_pkg.sv -----
// sbsa_pkg: shared types and codes of the sprite batch slot assigner
// command, result kind, status and register index codes, and the result record
// no dependencies
package sbsa_pkg;

	localparam int CMD_W     = 2;
	localparam int ID_IN_W   = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 11;
	localparam int MS_W      = 11;
	localparam int MT_W      = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_END   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_FLUSH = 2'd1,
		KIND_ACK   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_STARTED = 2'd1,
		ST_NO_TEXTURE  = 2'd2,
		ST_STARTED     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPRITE_LIMIT = 2'd0,
		CFG_SLOT_LIMIT   = 2'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [3:0]  texture_slot;
		logic [11:0] base_vertex;
		logic [10:0] batch_sprites;
		logic [4:0]  batch_textures;
		logic        last;
	} result_t;

	function automatic result_t mk_result(input kind_t k, input status_t s,
			input logic [3:0] slot, input logic [11:0] base,
			input logic [10:0] ns, input logic [4:0] nt, input logic lst);
		result_t r;
		r.kind           = k;
		r.status         = s;
		r.texture_slot   = slot;
		r.base_vertex    = base;
		r.batch_sprites  = ns;
		r.batch_textures = nt;
		r.last           = lst;
		return r;
	endfunction

endpackage

// ----- hw/rtl/sprite_batch_slot_assigner_core.sv -----
// sprite_batch_slot_assigner_core: top level of the sprite batch slot assigner
// control, limit registers, chain of slot cells and the result queue
// depends on sbsa_pkg, sbsa_cell, sbsa_out_queue

// Takes begin, add and end commands and groups sprites into batches. The transfer
// registers command and texture id; the evaluation step then runs the id through the
// chain of slot cells, updates the batch counts and the slot table and loads one or
// two results into the output queue. That step waits until the queue is empty, so
// while results of a command are not taken, or while the two results of a flush
// drain (one per cycle while out_ready is high), the next command sits in its
// register and no further command is accepted. Limits written through the
// configuration port are clamped on write; no clearing pass runs after reset.
module sprite_batch_slot_assigner_core #(
	parameter int BATCH_SPRITES = 1024,
	parameter int MAX_SLOTS     = 16,
	parameter int ID_WIDTH      = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sbsa_pkg::CMD_W-1:0]          cmd,
	input  logic                                has_texture,
	input  logic [sbsa_pkg::ID_IN_W-1:0]        texture_id,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          kind,
	output logic [1:0]                          status,
	output logic [3:0]                          texture_slot,
	output logic [11:0]                         base_vertex,
	output logic [10:0]                         batch_sprites,
	output logic [4:0]                          batch_textures,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sbsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sbsa_pkg::CFG_DAT_W-1:0]      cfg_data
);
	import sbsa_pkg::*;

	localparam int ID_W   = ID_WIDTH < ID_IN_W ? ID_WIDTH : ID_IN_W;
	localparam int SC_W   = $clog2(BATCH_SPRITES + 1);
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int SLOT_W = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
	localparam int LS_W   = SC_W > MS_W ? SC_W : MS_W;
	localparam int LT_W   = CNT_W > MT_W ? CNT_W : MT_W;
	localparam int LIM_SPR_RST  = BATCH_SPRITES < 1024 ? BATCH_SPRITES : 1024;
	localparam int LIM_SLOT_RST = MAX_SLOTS < 16 ? MAX_SLOTS : 16;

	// limit registers, clamped on write
	logic [SC_W-1:0]  lim_spr_q;
	logic [CNT_W-1:0] lim_slot_q;
	logic [LS_W-1:0]  ms_ext;
	logic [LT_W-1:0]  mt_ext;

	// batch state
	logic             open_q;
	logic [SC_W-1:0]  sc_q;
	logic [CNT_W-1:0] slc_q;

	// registered command
	logic             busy_q;
	cmd_t             cmd_s1;
	logic             tex_s1;
	logic [ID_W-1:0]  key_s1;

	// evaluation
	logic             eval;
	logic             q_empty;
	logic             open_n;
	logic [SC_W-1:0]  sc_n;
	logic [CNT_W-1:0] slc_n;
	logic             tbl_we;
	logic [SLOT_W-1:0] tbl_widx;
	logic [1:0]       nres;
	result_t          r0;
	result_t          r1;
	result_t          head;
	logic             full;
	logic [SLOT_W-1:0] add_slot;

	// chain links
	logic              hit_l  [0:MAX_SLOTS];
	logic [SLOT_W-1:0] slot_l [0:MAX_SLOTS];
	logic [MAX_SLOTS-1:0] match_v;

	assign cfg_ready = 1'b1;
	assign ms_ext    = LS_W'(cfg_data);
	assign mt_ext    = LT_W'(cfg_data[MT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_spr_q  <= SC_W'(LIM_SPR_RST);
			lim_slot_q <= CNT_W'(LIM_SLOT_RST);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SPRITE_LIMIT: begin
					if (ms_ext == '0)
						lim_spr_q <= SC_W'(1);
					else if (ms_ext > LS_W'(BATCH_SPRITES))
						lim_spr_q <= SC_W'(BATCH_SPRITES);
					else
						lim_spr_q <= SC_W'(ms_ext);
				end
				CFG_SLOT_LIMIT: begin
					if (mt_ext == '0)
						lim_slot_q <= CNT_W'(1);
					else if (mt_ext > LT_W'(MAX_SLOTS))
						lim_slot_q <= CNT_W'(MAX_SLOTS);
					else
						lim_slot_q <= CNT_W'(mt_ext);
				end
				default: ;
			endcase
		end
	end

	assign in_ready = !busy_q;
	assign eval     = busy_q && q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			open_q <= 1'b0;
			sc_q   <= '0;
			slc_q  <= '0;
		end else begin
			if (in_valid && in_ready)
				busy_q <= 1'b1;
			else if (eval)
				busy_q <= 1'b0;
			if (eval) begin
				open_q <= open_n;
				sc_q   <= sc_n;
				slc_q  <= slc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_t'(cmd);
			tex_s1 <= has_texture;
			key_s1 <= texture_id[ID_W-1:0];
		end
	end

	// chain of slot cells, a hit ripples toward the end and a later match takes over the slot
	assign hit_l[0]  = 1'b0;
	assign slot_l[0] = '0;

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		sbsa_cell #(
			.ID_W   (ID_W),
			.SLOT_W (SLOT_W),
			.CNT_W  (CNT_W),
			.INDEX  (i)
		) u_cell (
			.clk        (clk),
			.key        (key_s1),
			.slot_count (slc_q),
			.wr_en      (tbl_we),
			.wr_idx     (tbl_widx),
			.hit_in     (hit_l[i]),
			.slot_in    (slot_l[i]),
			.hit_out    (hit_l[i+1]),
			.slot_out   (slot_l[i+1]),
			.match      (match_v[i])
		);
	end

	assign full     = (sc_q >= lim_spr_q) || (!hit_l[MAX_SLOTS] && slc_q >= lim_slot_q);
	assign add_slot = hit_l[MAX_SLOTS] ? slot_l[MAX_SLOTS] : slc_q[SLOT_W-1:0];

	always_comb begin
		open_n   = open_q;
		sc_n     = sc_q;
		slc_n    = slc_q;
		tbl_we   = 1'b0;
		tbl_widx = slc_q[SLOT_W-1:0];
		nres     = 2'd0;
		r0       = '0;
		r1       = '0;
		case (cmd_s1)
			CMD_BEGIN: begin
				nres = 2'd1;
				if (open_q) begin
					r0 = mk_result(KIND_ACK, ST_STARTED, '0, '0, '0, '0, 1'b1);
				end else begin
					open_n = 1'b1;
					sc_n   = '0;
					slc_n  = '0;
					r0 = mk_result(KIND_ACK, ST_OK, '0, '0, '0, '0, 1'b1);
				end
			end
			CMD_END: begin
				if (!open_q) begin
					nres = 2'd1;
					r0 = mk_result(KIND_ACK, ST_NOT_STARTED, '0, '0, '0, '0, 1'b1);
				end else begin
					open_n = 1'b0;
					sc_n   = '0;
					slc_n  = '0;
					if (sc_q != '0) begin
						nres = 2'd2;
						r0 = mk_result(KIND_FLUSH, ST_OK, '0, '0, 11'(sc_q), 5'(slc_q), 1'b0);
						r1 = mk_result(KIND_ACK, ST_OK, '0, '0, '0, '0, 1'b1);
					end else begin
						nres = 2'd1;
						r0 = mk_result(KIND_ACK, ST_OK, '0, '0, '0, '0, 1'b1);
					end
				end
			end
			CMD_ADD: begin
				if (!open_q) begin
					nres = 2'd1;
					r0 = mk_result(KIND_ADD, ST_NOT_STARTED, '0, '0, '0, '0, 1'b1);
				end else if (!tex_s1) begin
					if (sc_q != '0) begin
						nres  = 2'd2;
						sc_n  = '0;
						slc_n = '0;
						r0 = mk_result(KIND_FLUSH, ST_OK, '0, '0, 11'(sc_q), 5'(slc_q), 1'b0);
						r1 = mk_result(KIND_ADD, ST_NO_TEXTURE, '0, '0, '0, '0, 1'b1);
					end else begin
						nres = 2'd1;
						r0 = mk_result(KIND_ADD, ST_NO_TEXTURE, '0, '0, '0, '0, 1'b1);
					end
				end else if (full) begin
					// flush, then place the sprite as the first of a fresh batch
					tbl_we   = 1'b1;
					tbl_widx = '0;
					sc_n     = SC_W'(1);
					slc_n    = CNT_W'(1);
					if (sc_q != '0) begin
						nres = 2'd2;
						r0 = mk_result(KIND_FLUSH, ST_OK, '0, '0, 11'(sc_q), 5'(slc_q), 1'b0);
						r1 = mk_result(KIND_ADD, ST_OK, '0, '0, '0, '0, 1'b1);
					end else begin
						nres = 2'd1;
						r0 = mk_result(KIND_ADD, ST_OK, '0, '0, '0, '0, 1'b1);
					end
				end else begin
					nres = 2'd1;
					sc_n = sc_q + SC_W'(1);
					if (!hit_l[MAX_SLOTS]) begin
						tbl_we = 1'b1;
						slc_n  = slc_q + CNT_W'(1);
					end
					r0 = mk_result(KIND_ADD, ST_OK, 4'(add_slot), 12'({sc_q, 2'b00}),
						'0, '0, 1'b1);
				end
			end
			default: ;
		endcase
		if (!eval)
			tbl_we = 1'b0;
	end

	sbsa_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (eval),
		.load_n    (nres),
		.r0        (r0),
		.r1        (r1),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.empty     (q_empty),
		.head      (head)
	);

	assign kind           = head.kind;
	assign status         = head.status;
	assign texture_slot   = head.texture_slot;
	assign base_vertex    = head.base_vertex;
	assign batch_sprites  = head.batch_sprites;
	assign batch_textures = head.batch_textures;
	assign last           = head.last;

	// a texture id lives in at most one slot of the batch
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot0(match_v))
		else $error("texture id found in more than one slot");

	// sprites and slots are emptied together
	a_counts_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(sc_q == '0) == (slc_q == '0))
		else $error("sprite and slot counts disagree on an empty batch");

	// a closed batch holds nothing
	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (sc_q == '0))
		else $error("closed batch still holds sprites");

	// a command accepted at an edge is evaluated only after that edge
	a_no_eval_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> busy_q && $stable(open_q))
		else $error("command evaluated in its transfer cycle");

endmodule

// ----- hw/rtl/sbsa_cell.sv -----
// sbsa_cell: one texture slot of the batch, holding its texture id
// compares the registered key and passes any hit down the chain, a later match taking over the slot
// no dependencies
module sbsa_cell #(
	parameter int ID_W   = 16,
	parameter int SLOT_W = 4,
	parameter int CNT_W  = 5,
	parameter int INDEX  = 0
) (
	input  logic              clk,
	input  logic [ID_W-1:0]   key,
	input  logic [CNT_W-1:0]  slot_count,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_idx,
	input  logic              hit_in,
	input  logic [SLOT_W-1:0] slot_in,
	output logic              hit_out,
	output logic [SLOT_W-1:0] slot_out,
	output logic              match
);
	logic [ID_W-1:0] entry_q;
	logic            live;

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == SLOT_W'(INDEX)) begin
			entry_q <= key;
		end
	end

	// only slots below the fill count belong to the batch
	assign live     = CNT_W'(INDEX) < slot_count;
	assign match    = live && (entry_q == key);
	assign hit_out  = hit_in | match;
	assign slot_out = match ? SLOT_W'(INDEX) : slot_in;

endmodule

// ----- hw/rtl/sbsa_out_queue.sv -----
// sbsa_out_queue: two-entry result queue between the evaluation step and the output
// loaded with up to two results at once while empty, drained one per transfer
// depends on sbsa_pkg
module sbsa_out_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [1:0]      load_n,
	input  sbsa_pkg::result_t r0,
	input  sbsa_pkg::result_t r1,
	input  logic            out_ready,
	output logic            out_valid,
	output logic            empty,
	output sbsa_pkg::result_t head
);
	import sbsa_pkg::*;

	result_t   e0_q;
	result_t   e1_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= load_n;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			e0_q <= r0;
			e1_q <= r1;
		end else if (out_valid && out_ready) begin
			e0_q <= e1_q;
		end
	end

	assign out_valid = cnt_q != 2'd0;
	assign empty     = cnt_q == 2'd0;
	assign head      = e0_q;

endmodule

// ----- sim/sprite_batch_slot_assigner_core_tb.sv -----
// sprite_batch_slot_assigner_core_tb: self-checking bench for the sprite batch slot assigner
// directed command table, a full-size batch, then random batch sequences checked against a behavioral predictor
// depends on sbsa_pkg and sprite_batch_slot_assigner_core
module sprite_batch_slot_assigner_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbsa_pkg::*;

	localparam int BATCH_SPRITES = 1024;
	localparam int MAX_SLOTS     = 16;
	localparam int ID_WIDTH      = 16;
	localparam int SHOW_LIMIT    = 10;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 20;
	localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] cfg_sel;
		logic [CFG_DAT_W-1:0] cfg_val;
		logic [CMD_W-1:0]     cmd;
		logic                 has_tex;
		logic [ID_IN_W-1:0]   tex_id;
		logic                 typed;
		result_t              want;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CMD_W-1:0]     cmd;
	logic                 has_texture;
	logic [ID_IN_W-1:0]   texture_id;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           kind;
	logic [1:0]           status;
	logic [3:0]           texture_slot;
	logic [11:0]          base_vertex;
	logic [10:0]          batch_sprites;
	logic [4:0]           batch_textures;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	// predicted batch state
	logic        batch_open_m;
	int          sprites_m;
	int          slots_m;
	logic [15:0] slot_ids_m [MAX_SLOTS];
	int          sprite_cap;
	int          slot_cap;
	result_t     awaited_results [$];

	plan_row_t   plan [$];
	logic [15:0] tex_pool [MAX_SLOTS];
	logic        hold_off_req = 1'b0;
	logic        quiet_tail = 1'b0;
	int          fault_cnt = 0;
	int          items_taken = 0;
	int          cfg_writes = 0;
	int          results_seen = 0;
	int          flushes_seen = 0;

	sprite_batch_slot_assigner_core #(
		.BATCH_SPRITES(BATCH_SPRITES),
		.MAX_SLOTS(MAX_SLOTS),
		.ID_WIDTH(ID_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.has_texture(has_texture),
		.texture_id(texture_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.status(status),
		.texture_slot(texture_slot),
		.base_vertex(base_vertex),
		.batch_sprites(batch_sprites),
		.batch_textures(batch_textures),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// append one result to the tail of the expected list
	function automatic void queue_result(input result_t r);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	function automatic void plan_add(input plan_row_t r);
		plan.insert(plan.size(), r);
	endfunction

	// slot of an id already in the batch, else the next free one, -1 when the batch is out of slots
	function automatic int lookup_slot(input logic [15:0] id);
		for (int i = 0; i < slots_m; i++) begin
			if (slot_ids_m[i] == id) return i;
		end
		if (slots_m >= slot_cap) return -1;
		return slots_m;
	endfunction

	function automatic void flush_batch_m();
		if (sprites_m != 0) begin
			queue_result(mk_result(KIND_FLUSH, ST_OK, 4'd0, 12'd0,
				11'(sprites_m), 5'(slots_m), 1'b0));
		end
		sprites_m = 0;
		slots_m   = 0;
	endfunction

	function automatic void predict_batch_results(input logic [1:0] c, input logic has,
			input logic [15:0] id);
		int slot;
		case (c)
			CMD_BEGIN: begin
				if (batch_open_m) begin
					queue_result(mk_result(KIND_ACK, ST_STARTED, 4'd0, 12'd0,
						11'd0, 5'd0, 1'b1));
				end else begin
					sprites_m    = 0;
					slots_m      = 0;
					batch_open_m = 1'b1;
					queue_result(mk_result(KIND_ACK, ST_OK, 4'd0, 12'd0,
						11'd0, 5'd0, 1'b1));
				end
			end
			CMD_END: begin
				if (!batch_open_m) begin
					queue_result(mk_result(KIND_ACK, ST_NOT_STARTED, 4'd0, 12'd0,
						11'd0, 5'd0, 1'b1));
				end else begin
					flush_batch_m();
					batch_open_m = 1'b0;
					queue_result(mk_result(KIND_ACK, ST_OK, 4'd0, 12'd0,
						11'd0, 5'd0, 1'b1));
				end
			end
			CMD_ADD: begin
				if (!batch_open_m) begin
					queue_result(mk_result(KIND_ADD, ST_NOT_STARTED, 4'd0, 12'd0,
						11'd0, 5'd0, 1'b1));
				end else if (!has) begin
					flush_batch_m();
					queue_result(mk_result(KIND_ADD, ST_NO_TEXTURE, 4'd0, 12'd0,
						11'd0, 5'd0, 1'b1));
				end else begin
					slot = -1;
					if (sprites_m < sprite_cap) slot = lookup_slot(id);
					// batch full: flush and retry into the empty batch
					if (slot < 0) begin
						flush_batch_m();
						slot = lookup_slot(id);
						if (slot < 0) slot = 0;
					end
					if (slot == slots_m) begin
						slot_ids_m[slot] = id;
						slots_m++;
					end
					queue_result(mk_result(KIND_ADD, ST_OK, 4'(slot),
						12'(sprites_m * 4), 11'd0, 5'd0, 1'b1));
					sprites_m++;
				end
			end
			default: ;
		endcase
	endfunction

	// limits are clamped into their legal range on write
	function automatic void apply_limit(input logic [1:0] idx, input logic [10:0] data);
		int v;
		case (idx)
			CFG_SPRITE_LIMIT: begin
				v = int'(data);
				sprite_cap = (v == 0) ? 1 : (v > BATCH_SPRITES) ? BATCH_SPRITES : v;
			end
			CFG_SLOT_LIMIT: begin
				v = int'(data[4:0]);
				slot_cap = (v == 0) ? 1 : (v > MAX_SLOTS) ? MAX_SLOTS : v;
			end
			default: ;
		endcase
	endfunction

	function automatic plan_row_t item_row(input logic [1:0] c, input logic h,
			input logic [15:0] id);
		plan_row_t r;
		r.is_cfg  = 1'b0;
		r.cfg_sel = '0;
		r.cfg_val = '0;
		r.cmd     = c;
		r.has_tex = h;
		r.tex_id  = id;
		r.typed   = 1'b0;
		r.want    = '0;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input logic [1:0] c, input logic h,
			input logic [15:0] id, input kind_t k, input status_t s, input logic [3:0] slot,
			input logic [11:0] base);
		plan_row_t r;
		r       = item_row(c, h, id);
		r.typed = 1'b1;
		r.want  = mk_result(k, s, slot, base, 11'd0, 5'd0, 1'b1);
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [10:0] data);
		plan_row_t r;
		r         = item_row(CMD_BEGIN, 1'b0, 16'd0);
		r.is_cfg  = 1'b1;
		r.cfg_sel = idx;
		r.cfg_val = data;
		return r;
	endfunction

	function automatic void refill_pool();
		foreach (tex_pool[i]) tex_pool[i] = 16'($urandom);
	endfunction

	task automatic offer_item(input logic [1:0] c, input logic has, input logic [15:0] id,
			input logic typed, input result_t want);
		int gap;
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		cmd         <= c;
		has_texture <= has;
		texture_id  <= id;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_batch_results(c, has, id);
		if (typed) begin
			void'(awaited_results.pop_back());
			queue_result(want);
		end
		if (c != CMD_SPARE) items_taken++;
	endtask

	task automatic send(input logic [1:0] c, input logic has, input logic [15:0] id);
		offer_item(c, has, id, 1'b0, '0);
	endtask

	// block idle: nothing in flight and every expected result drained
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [1:0] idx, input logic [10:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_limit(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed begin/add/end batches, the rest random commands
	task automatic run_mix(input logic [10:0] spr_data, input logic [10:0] tex_data,
			input int n_items, input int span, input logic hold);
		int start;
		int k;
		settle();
		write_limit(CFG_SPRITE_LIMIT, spr_data);
		write_limit(CFG_SLOT_LIMIT, tex_data);
		refill_pool();
		// long output hold-off while commands keep coming
		if (hold) hold_off_req = 1'b1;
		start = items_taken;
		while (items_taken - start < n_items) begin
			if ($urandom_range(0, 99) < 85) begin
				send(CMD_BEGIN, 1'($urandom_range(0, 1)), 16'($urandom));
				k = $urandom_range(1, (sprite_cap < 16) ? 3 * sprite_cap + 2 : 48);
				repeat (k) begin
					send(CMD_ADD, $urandom_range(0, 19) != 0,
						($urandom_range(0, 9) == 0) ? 16'($urandom)
							: tex_pool[$urandom_range(0, span - 1)]);
				end
				send(CMD_END, 1'($urandom_range(0, 1)), 16'($urandom));
			end else begin
				send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 16'($urandom));
			end
		end
	endtask

	// output side: random stall bursts, plus one long hold-off on request
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 17);
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want_r;
		if (arst_n && out_valid && out_ready) begin
			got = {kind, status, texture_slot, base_vertex, batch_sprites, batch_textures, last};
			results_seen++;
			if (got.kind == KIND_FLUSH) flushes_seen++;
			if (awaited_results.size() == 0) begin
				fault_cnt++;
				if (fault_cnt <= SHOW_LIMIT)
					$display("%0t: result with nothing expected: kind %0d status %0d", $realtime,
						got.kind, got.status);
			end else begin
				want_r = awaited_results.pop_front();
				if (got.kind !== want_r.kind || got.status !== want_r.status ||
						got.texture_slot !== want_r.texture_slot ||
						got.base_vertex !== want_r.base_vertex ||
						got.batch_sprites !== want_r.batch_sprites ||
						got.batch_textures !== want_r.batch_textures ||
						got.last !== want_r.last) begin
					fault_cnt++;
					if (fault_cnt <= SHOW_LIMIT) begin
						$write("%0t: mismatch kind/status/slot/base/sprites/textures/last",
							$realtime);
						$write(" exp %0d/%0d/%0d/%0d/%0d/%0d/%0d", want_r.kind, want_r.status,
							want_r.texture_slot, want_r.base_vertex, want_r.batch_sprites,
							want_r.batch_textures, want_r.last);
						$display(" got %0d/%0d/%0d/%0d/%0d/%0d/%0d", got.kind, got.status,
							got.texture_slot, got.base_vertex, got.batch_sprites,
							got.batch_textures, got.last);
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		in_valid     = 1'b0;
		cmd          = CMD_BEGIN;
		has_texture  = 1'b0;
		texture_id   = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_SPRITE_LIMIT;
		cfg_data     = '0;
		arst_n       = 1'b0;
		batch_open_m = 1'b0;
		sprites_m    = 0;
		slots_m      = 0;
		sprite_cap   = BATCH_SPRITES;
		slot_cap     = MAX_SLOTS;
		foreach (slot_ids_m[i]) slot_ids_m[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// closed-batch errors, reuse, no-texture flush, then both limits at small values
		plan_add(typed_row(CMD_END, 1'b0, 16'h0000, KIND_ACK, ST_NOT_STARTED, 4'd0, 12'd0));
		plan_add(typed_row(CMD_ADD, 1'b1, 16'h1234, KIND_ADD, ST_NOT_STARTED, 4'd0, 12'd0));
		plan_add(item_row(CMD_SPARE, 1'b1, 16'hFFFF));
		plan_add(typed_row(CMD_BEGIN, 1'b0, 16'h0000, KIND_ACK, ST_OK, 4'd0, 12'd0));
		plan_add(typed_row(CMD_BEGIN, 1'b1, 16'hFFFF, KIND_ACK, ST_STARTED, 4'd0, 12'd0));
		plan_add(typed_row(CMD_ADD, 1'b1, 16'h0000, KIND_ADD, ST_OK, 4'd0, 12'd0));
		plan_add(item_row(CMD_ADD, 1'b1, 16'hFFFF));
		plan_add(item_row(CMD_ADD, 1'b1, 16'h0000));
		plan_add(item_row(CMD_ADD, 1'b0, 16'hA5A5));
		plan_add(typed_row(CMD_ADD, 1'b0, 16'h5A5A, KIND_ADD, ST_NO_TEXTURE, 4'd0, 12'd0));
		plan_add(item_row(CMD_ADD, 1'b1, 16'h8001));
		plan_add(item_row(CMD_END, 1'b0, 16'h0000));
		plan_add(typed_row(CMD_END, 1'b1, 16'hFFFF, KIND_ACK, ST_NOT_STARTED, 4'd0, 12'd0));
		plan_add(cfg_row(CFG_SPRITE_LIMIT, 11'd3));
		plan_add(cfg_row(CFG_SLOT_LIMIT, 11'd2));
		plan_add(typed_row(CMD_BEGIN, 1'b0, 16'h0000, KIND_ACK, ST_OK, 4'd0, 12'd0));
		plan_add(item_row(CMD_ADD, 1'b1, 16'h0011));
		plan_add(item_row(CMD_ADD, 1'b1, 16'h0022));
		plan_add(item_row(CMD_ADD, 1'b1, 16'h0033));
		plan_add(item_row(CMD_ADD, 1'b1, 16'h0033));
		plan_add(item_row(CMD_ADD, 1'b1, 16'h0044));
		plan_add(item_row(CMD_ADD, 1'b1, 16'h0033));
		plan_add(item_row(CMD_END, 1'b0, 16'h0000));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_limit(plan[i].cfg_sel, plan[i].cfg_val);
			end else begin
				offer_item(plan[i].cmd, plan[i].has_tex, plan[i].tex_id, plan[i].typed,
					plan[i].want);
			end
		end

		// one full-size batch: limits written past their range, sprite limit hit at 1024
		settle();
		write_limit(CFG_SPRITE_LIMIT, 11'd2047);
		write_limit(CFG_SLOT_LIMIT, 11'd31);
		refill_pool();
		send(CMD_BEGIN, 1'b0, 16'h0000);
		repeat (BATCH_SPRITES + 6)
			send(CMD_ADD, 1'b1, tex_pool[$urandom_range(0, MAX_SLOTS - 1)]);
		send(CMD_END, 1'b0, 16'h0000);

		// zero limits act as one sprite and one slot
		run_mix(11'd0, 11'd0, 60, 3, 1'b0);

		run_mix(11'd5, 11'd3, 150, 6, 1'b1);

		settle();
		write_limit(CFG_SPARE, 11'($urandom));
		run_mix(11'($urandom_range(1, 40)), 11'($urandom), 80, $urandom_range(1, 16), 1'b0);
		run_mix(11'($urandom_range(1, 40)), 11'($urandom), 80, $urandom_range(1, 16), 1'b0);

		quiet_tail = 1'b1;
		run_mix(11'd7, 11'd4, 60, 5, 1'b0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d commands and %0d limit writes; %0d results checked, %0d of them flushes",
			items_taken, cfg_writes, results_seen, flushes_seen);
		$display("limits from 1/1 up to a full 1024-sprite batch, output held off %0d cycles once",
			HOLD_CYCLES);
		if (fault_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d failing results", fault_cnt);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
